/* hdl/crsf_pkg.sv */
// Shared types, constants and the CRC-8 step for the RC channel frame parser.
package crsf_pkg;

  localparam int FRAME_BYTES   = 26;
  localparam int CHANNEL_COUNT = 16;
  localparam int CHANNEL_BITS  = 11;

  // sync, length, type and crc frame the payload
  localparam int PAYLOAD_BYTES = FRAME_BYTES - 4;
  localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
  localparam int MAX_LEN       = FRAME_BYTES - 2;
  localparam int POS_W         = $clog2(FRAME_BYTES + 1);

  localparam logic [7:0] CRC_POLY = 8'hD5;

  localparam logic [CHANNEL_BITS-1:0] RAW_LOW  = CHANNEL_BITS'(172);
  localparam logic [CHANNEL_BITS-1:0] RAW_HIGH = CHANNEL_BITS'(1811);
  localparam logic [CHANNEL_BITS-1:0] RAW_MID  = CHANNEL_BITS'(992);

  // floor(m * 1000 / 819) == (m * SCALE_RECIP) >> SCALE_SHIFT for m <= 820
  localparam logic [30:0] SCALE_RECIP = 31'd1311041000;
  localparam int          SCALE_SHIFT = 30;
  localparam logic [9:0]  SCALE_SPAN  = 10'd1000;

  localparam logic [7:0] SYNC_RESET = 8'd200;
  localparam logic [7:0] TYPE_RESET = 8'd22;

  // register select, taken from paddr[2]
  localparam logic REG_SYNC = 1'b0;
  localparam logic REG_TYPE = 1'b1;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_LEN,
    ST_BODY,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       crc_first;
    logic       crc_update;
    logic       type_load;
    logic       payload_load;
    logic       issue;
    logic       issue_last;
    logic [3:0] issue_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic adv;
    logic crc_ok;
    logic type_ok;
    logic last_taken;
  } dp_stat_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* hdl/crsf_ctrl.sv */
// Frame sequencer: sync hunt, length check, byte counting and channel issue.
module crsf_ctrl import crsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] sync_value,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  state_t           st_r, st_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] len_r, len_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic             issued_all_r, issued_all_nxt;

  logic in_acc;
  logic len_bad;
  logic frame_done;
  logic frame_good;

  assign in_ready = (st_r != ST_EMIT);
  assign in_acc   = in_valid && in_ready;
  assign len_bad  = (in_rx_byte == 8'd0) || (in_rx_byte > 8'(MAX_LEN));

  assign frame_done = in_acc && (st_r == ST_BODY) &&
                      (({1'b0, pos_r} + 1'b1) == ({1'b0, len_r} + 2'd2));
  assign frame_good = frame_done && (len_r == POS_W'(MAX_LEN)) &&
                      stat.type_ok && stat.crc_ok;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_HUNT: begin
        if (in_acc && (in_rx_byte == sync_value)) st_nxt = ST_LEN;
      end
      ST_LEN: begin
        if (in_acc) st_nxt = len_bad ? ST_HUNT : ST_BODY;
      end
      ST_BODY: begin
        if (frame_done) st_nxt = frame_good ? ST_EMIT : ST_HUNT;
      end
      ST_EMIT: begin
        if (stat.last_taken) st_nxt = ST_HUNT;
      end
      default: st_nxt = ST_HUNT;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd              = '0;
    cmd.type_load    = in_acc && (st_r == ST_BODY) && (pos_r == POS_W'(2));
    cmd.crc_first    = cmd.type_load;
    cmd.crc_update   = in_acc && (st_r == ST_BODY) && (pos_r <= POS_W'(MAX_LEN));
    cmd.payload_load = in_acc && (st_r == ST_BODY) && (pos_r >= POS_W'(3)) &&
                       (pos_r <= POS_W'(MAX_LEN));
    cmd.issue        = (st_r == ST_EMIT) && !issued_all_r && stat.adv;
    cmd.issue_last   = (cnt_r == 4'(CHANNEL_COUNT - 1));
    cmd.issue_idx    = cnt_r;
  end

  // counters
  always_comb begin
    pos_nxt        = pos_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    issued_all_nxt = issued_all_r;
    if (in_acc && (st_r == ST_LEN)) begin
      len_nxt = POS_W'(in_rx_byte);
      pos_nxt = POS_W'(2);
    end
    if (in_acc && (st_r == ST_BODY)) pos_nxt = pos_r + 1'b1;
    if (frame_good) begin
      cnt_nxt        = '0;
      issued_all_nxt = 1'b0;
    end
    if (cmd.issue) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cmd.issue_last) issued_all_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_HUNT;
      pos_r        <= '0;
      len_r        <= '0;
      cnt_r        <= '0;
      issued_all_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      pos_r        <= pos_nxt;
      len_r        <= len_nxt;
      cnt_r        <= cnt_nxt;
      issued_all_r <= issued_all_nxt;
    end
  end

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT && st_nxt != ST_EMIT) |-> issued_all_r)
    else $error("left burst before all channels were issued");

  a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_BODY) |-> (len_r != '0 && len_r <= POS_W'(MAX_LEN)))
    else $error("frame body entered with illegal length");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_BODY) |-> (({1'b0, pos_r} + 1'b1) <= ({1'b0, len_r} + 2'd2)))
    else $error("byte count ran past frame end");

endmodule

/* hdl/crsf_datapath.sv */
// Frame datapath: running CRC, payload shift line and three-stage channel scaler.
module crsf_datapath import crsf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic [7:0]              rx_byte,
  input  logic [7:0]              chan_type,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [3:0]              out_chan_index,
  output logic [10:0]             out_raw_value,
  output logic signed [10:0]      out_scaled_value,
  output logic [9:0]              out_throttle_value,
  output logic                    out_last_channel
);

  logic [7:0]           crc_r, crc_nxt;
  logic [7:0]           type_r;
  logic [PAYLOAD_W-1:0] payload_r, payload_nxt;

  logic                    s1_v_r, s2_v_r, out_v_r;
  logic [3:0]              s1_idx_r, s2_idx_r, out_idx_r;
  logic [CHANNEL_BITS-1:0] s1_raw_r, s2_raw_r, out_raw_r;
  logic                    s1_last_r, s2_last_r, out_last_r;
  logic                    s1_neg_r, s2_neg_r;
  logic [9:0]              s1_mag_r, s2_q_r;
  logic [10:0]             out_scaled_r;
  logic [9:0]              out_thr_r;

  logic                    adv;
  logic [CHANNEL_BITS-1:0] raw, clamped;
  logic                    neg;
  logic [9:0]              mag;
  logic [40:0]             prod;
  logic [9:0]              q_clip;
  logic [10:0]             scaled, thr_sum;

  // pipeline moves unless a result is waiting on the output
  assign adv = !out_v_r || out_ready;

  assign stat.adv        = adv;
  assign stat.crc_ok     = (crc_r == rx_byte);
  assign stat.type_ok    = (type_r == chan_type);
  assign stat.last_taken = out_v_r && out_ready && out_last_r;

  always_comb begin
    crc_nxt = crc_r;
    if (cmd.crc_first)       crc_nxt = crc8_byte(8'd0, rx_byte);
    else if (cmd.crc_update) crc_nxt = crc8_byte(crc_r, rx_byte);
  end

  // payload bytes enter at the top; channel 0 ends up in the low bits
  always_comb begin
    payload_nxt = payload_r;
    if (cmd.payload_load) payload_nxt = {rx_byte, payload_r[PAYLOAD_W-1:8]};
    else if (cmd.issue)   payload_nxt = payload_r >> CHANNEL_BITS;
  end

  // stage 1: clamp and split into sign and magnitude around center
  always_comb begin
    raw = payload_r[CHANNEL_BITS-1:0];
    if (raw < RAW_LOW)       clamped = RAW_LOW;
    else if (raw > RAW_HIGH) clamped = RAW_HIGH;
    else                     clamped = raw;
    neg = (clamped < RAW_MID);
    mag = neg ? 10'(RAW_MID - clamped) : 10'(clamped - RAW_MID);
  end

  // stage 2: divide by 819 through a scaled reciprocal, exact over the clamped range
  assign prod = 41'(s1_mag_r) * 41'(SCALE_RECIP);

  // stage 3: restore sign, throttle from the value clipped to the span
  always_comb begin
    scaled  = s2_neg_r ? (11'd0 - {1'b0, s2_q_r}) : {1'b0, s2_q_r};
    q_clip  = (s2_q_r > SCALE_SPAN) ? SCALE_SPAN : s2_q_r;
    thr_sum = s2_neg_r ? ({1'b0, SCALE_SPAN} - {1'b0, q_clip})
                       : ({1'b0, SCALE_SPAN} + {1'b0, q_clip});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= cmd.issue;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    crc_r     <= crc_nxt;
    payload_r <= payload_nxt;
    if (cmd.type_load) type_r <= rx_byte;
    if (adv) begin
      s1_idx_r     <= cmd.issue_idx;
      s1_raw_r     <= raw;
      s1_last_r    <= cmd.issue_last;
      s1_neg_r     <= neg;
      s1_mag_r     <= mag;
      s2_idx_r     <= s1_idx_r;
      s2_raw_r     <= s1_raw_r;
      s2_last_r    <= s1_last_r;
      s2_neg_r     <= s1_neg_r;
      s2_q_r       <= prod[SCALE_SHIFT+9:SCALE_SHIFT];
      out_idx_r    <= s2_idx_r;
      out_raw_r    <= s2_raw_r;
      out_last_r   <= s2_last_r;
      out_scaled_r <= scaled;
      out_thr_r    <= thr_sum[10:1];
    end
  end

  assign out_valid          = out_v_r;
  assign out_chan_index     = out_idx_r;
  assign out_raw_value      = out_raw_r;
  assign out_scaled_value   = $signed(out_scaled_r);
  assign out_throttle_value = out_thr_r;
  assign out_last_channel   = out_last_r;

  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (s1_mag_r <= 10'd820))
    else $error("clamped magnitude out of range");

  a_scaled_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ($signed(out_scaled_r) >= -11'sd1001 && $signed(out_scaled_r) <= 11'sd1000))
    else $error("scaled value out of range");

  a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_thr_r <= 10'd1000))
    else $error("throttle value out of range");

endmodule

/* hdl/crsf_rc_channel_frame_parser_top.sv */
// Top level: APB register file, frame sequencer and channel datapath.
// Bytes are taken one per cycle while hunting for sync and filling a frame.
// The final byte of a good channel frame (length 24, matching type, CRC-8
// 0xD5 over type and payload) starts a burst of sixteen channel beats;
// each passes a three-stage clamp/reciprocal-multiply/sign pipeline, and the
// beats leave one per cycle while out_ready is high. in_ready stays low
// after the final byte until the last beat of the burst is taken. Bad
// frames cost nothing beyond their own bytes.
// Registers: 0x0 sync byte (reset 200), 0x4 channel frame type (reset 22).
module crsf_rc_channel_frame_parser_top import crsf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_chan_index,
  output logic [10:0]        out_raw_value,
  output logic signed [10:0] out_scaled_value,
  output logic [9:0]         out_throttle_value,
  output logic               out_last_channel,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0] sync_r;
  logic [7:0] type_r;
  logic       cfg_wr;
  dp_cmd_t    cmd;
  dp_stat_t   stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_RESET;
      type_r <= TYPE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SYNC: sync_r <= pwdata[7:0];
        REG_TYPE: type_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SYNC: prdata = {24'd0, sync_r};
      REG_TYPE: prdata = {24'd0, type_r};
      default:  prdata = '0;
    endcase
  end

  crsf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .sync_value (sync_r),
    .stat       (stat),
    .cmd        (cmd)
  );

  crsf_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .rx_byte            (in_rx_byte),
    .chan_type          (type_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_chan_index     (out_chan_index),
    .out_raw_value      (out_raw_value),
    .out_scaled_value   (out_scaled_value),
    .out_throttle_value (out_throttle_value),
    .out_last_channel   (out_last_channel)
  );

endmodule
